// File: hw/rtl/frame_statistics_monitor_macros.svh
// Assertion macros for the frame statistics monitor.
// Included by the top level; no other dependencies.
`ifndef FRAME_STATISTICS_MONITOR_MACROS_SVH
`define FRAME_STATISTICS_MONITOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FSTAT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define FSTAT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/fstat_pkg.sv
// Shared types, codes and saturating helpers for the frame statistics monitor.
// No dependencies.
`default_nettype none

package fstat_pkg;

    localparam logic [31:0] PERIOD_MIN   = 32'd100000;
    localparam logic [31:0] PERIOD_RESET = 32'd1000000;

    typedef enum logic [2:0] {
        FN_DRAW     = 3'd0,
        FN_SOUND    = 3'd1,
        FN_UNDERRUN = 3'd2,
        FN_FRAME    = 3'd3,
        FN_BUFMEM   = 3'd4,
        FN_TEXMEM   = 3'd5,
        FN_RESTART  = 3'd6
    } t_func;

    typedef enum logic [0:0] {
        CFG_COUNTING = 1'b0,
        CFG_PERIOD   = 1'b1
    } t_cfg_idx;

    typedef enum logic [4:0] {
        ST_PERIOD     = 5'd0,
        ST_FRAMES     = 5'd1,
        ST_FRAMETOTAL = 5'd2,
        ST_BEST       = 5'd3,
        ST_WORST      = 5'd4,
        ST_DRAWS      = 5'd5,
        ST_DRAWWORST  = 5'd6,
        ST_VERTS      = 5'd7,
        ST_VERTWORST  = 5'd8,
        ST_BYTEWORST  = 5'd9,
        ST_BUFMEM     = 5'd10,
        ST_TEXMEM     = 5'd11,
        ST_SNDBLOCKS  = 5'd12,
        ST_SNDFRAMES  = 5'd13,
        ST_MIXSUM     = 5'd14,
        ST_MIXWORST   = 5'd15,
        ST_VOICEPEAK  = 5'd16,
        ST_UNDERRUNS  = 5'd17
    } t_stat_id;

    typedef struct packed {
        t_func       func;
        logic [47:0] now_us;
        logic [30:0] count_a;
        logic [31:0] count_b;
        logic [31:0] mix_us;
        logic [7:0]  voices;
    } t_item;

    // Snapshot of one summary run; byte_pk, buf_b and tex_b are two's complement.
    typedef struct packed {
        logic        valid;
        logic        has_sound;
        logic [47:0] elapsed;
        logic [31:0] frames;
        logic [47:0] ft_sum;
        logic [47:0] ft_min;
        logic [47:0] ft_max;
        logic [31:0] draws;
        logic [31:0] draw_pk;
        logic [47:0] verts;
        logic [31:0] vert_pk;
        logic [31:0] byte_pk;
        logic [47:0] buf_b;
        logic [47:0] tex_b;
        logic [31:0] snd_blocks;
        logic [47:0] snd_frames;
        logic [47:0] mix_sum;
        logic [31:0] mix_pk;
        logic [7:0]  voice_pk;
        logic [31:0] underruns;
    } t_run;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? '1 : s[31:0];
    endfunction

    function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [47:0] b);
        logic [48:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[48] ? '1 : s[47:0];
    endfunction

    function automatic logic [31:0] clamp_s32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31]) begin
            return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return s[31:0];
    endfunction

    function automatic logic [47:0] clamp_s48(input logic [47:0] a, input logic [31:0] b);
        logic [48:0] s;
        s = {a[47], a} + {{17{b[31]}}, b};
        if (s[48] != s[47]) begin
            return s[48] ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
        end
        return s[47:0];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/fstat_in_if.sv
// Event channel: valid/ready handshake with the event payload fields.
// No dependencies.
`default_nettype none

interface fstat_in_if;
    logic               valid;
    logic               ready;
    logic [2:0]         func;
    logic [47:0]        now_us;
    logic [30:0]        count_a;
    logic signed [31:0] count_b;
    logic [31:0]        mix_us;
    logic [7:0]         voices;

    modport source (output valid, func, now_us, count_a, count_b, mix_us, voices,
                    input ready);
    modport sink   (input valid, func, now_us, count_a, count_b, mix_us, voices,
                    output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fstat_out_if.sv
// Statistics channel: valid/ready handshake with one statistic per beat.
// No dependencies.
`default_nettype none

interface fstat_out_if;
    logic               valid;
    logic               ready;
    logic [4:0]         stat_id;
    logic signed [63:0] stat_value;
    logic               last_of_run;

    modport source (output valid, stat_id, stat_value, last_of_run, input ready);
    modport sink   (input valid, stat_id, stat_value, last_of_run, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/fstat_accum.sv
// Configuration registers, accumulators and per-event update logic.
// Depends on fstat_pkg; produces the snapshot for a summary run.
`default_nettype none

module fstat_accum (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [0:0]       i_cfg_index,
    input  wire logic [31:0]      i_cfg_data,
    input  wire fstat_pkg::t_item i_item,
    input  wire logic             i_item_valid,
    input  wire logic             i_rpt_busy,
    output logic                  o_take,
    output fstat_pkg::t_run       o_run
);
    import fstat_pkg::*;

    logic        r_counting;
    logic [31:0] r_period_len;

    logic [47:0] r_period_start, n_period_start;
    logic [47:0] r_last_frame,   n_last_frame;
    logic [31:0] r_frame_cnt,    n_frame_cnt;
    logic [47:0] r_ft_sum,       n_ft_sum;
    logic [47:0] r_ft_max,       n_ft_max;
    logic [47:0] r_ft_min,       n_ft_min;
    logic [31:0] r_draw_sum,     n_draw_sum;
    logic [47:0] r_vert_sum,     n_vert_sum;
    logic [31:0] r_draw_pk,      n_draw_pk;
    logic [31:0] r_vert_pk,      n_vert_pk;
    logic [31:0] r_byte_pk,      n_byte_pk;
    logic [31:0] r_draws_if,     n_draws_if;
    logic [31:0] r_verts_if,     n_verts_if;
    logic [31:0] r_bytes_if,     n_bytes_if;
    logic [47:0] r_buf_b,        n_buf_b;
    logic [47:0] r_tex_b,        n_tex_b;
    logic [31:0] r_snd_blocks,   n_snd_blocks;
    logic [47:0] r_snd_frames,   n_snd_frames;
    logic [47:0] r_mix_sum,      n_mix_sum;
    logic [31:0] r_mix_pk,       n_mix_pk;
    logic [7:0]  r_voice_pk,     n_voice_pk;
    logic [31:0] r_underruns,    n_underruns;

    logic [48:0] frame_diff;
    logic [48:0] period_diff;
    logic [47:0] elapsed;
    logic        period_end;

    assign o_take = i_item_valid && !(i_item.func == FN_FRAME && i_rpt_busy);

    assign frame_diff  = {1'b0, i_item.now_us} - {1'b0, r_last_frame};
    assign elapsed     = frame_diff[48] ? 48'd0 : frame_diff[47:0];
    assign period_diff = {1'b0, i_item.now_us} - {1'b0, r_period_start};

    always_comb begin
        n_period_start = r_period_start;
        n_last_frame   = r_last_frame;
        n_frame_cnt    = r_frame_cnt;
        n_ft_sum       = r_ft_sum;
        n_ft_max       = r_ft_max;
        n_ft_min       = r_ft_min;
        n_draw_sum     = r_draw_sum;
        n_vert_sum     = r_vert_sum;
        n_draw_pk      = r_draw_pk;
        n_vert_pk      = r_vert_pk;
        n_byte_pk      = r_byte_pk;
        n_draws_if     = r_draws_if;
        n_verts_if     = r_verts_if;
        n_bytes_if     = r_bytes_if;
        n_buf_b        = r_buf_b;
        n_tex_b        = r_tex_b;
        n_snd_blocks   = r_snd_blocks;
        n_snd_frames   = r_snd_frames;
        n_mix_sum      = r_mix_sum;
        n_mix_pk       = r_mix_pk;
        n_voice_pk     = r_voice_pk;
        n_underruns    = r_underruns;
        o_run          = '0;
        period_end     = !period_diff[48] && (period_diff[47:0] >= {16'd0, r_period_len});

        if (o_take) begin
            case (i_item.func)
                FN_DRAW: begin
                    if (r_counting) begin
                        n_draws_if = sat_add32(r_draws_if, 32'd1);
                        n_verts_if = sat_add32(r_verts_if, {1'b0, i_item.count_a});
                        n_bytes_if = clamp_s32(r_bytes_if, i_item.count_b);
                    end
                end
                FN_SOUND: begin
                    if (r_counting) begin
                        n_snd_blocks = sat_add32(r_snd_blocks, 32'd1);
                        n_snd_frames = sat_add48(r_snd_frames, {17'd0, i_item.count_a});
                        n_mix_sum    = sat_add48(r_mix_sum, {16'd0, i_item.mix_us});
                        if (i_item.mix_us > r_mix_pk) begin
                            n_mix_pk = i_item.mix_us;
                        end
                        if (i_item.voices > r_voice_pk) begin
                            n_voice_pk = i_item.voices;
                        end
                    end
                end
                FN_UNDERRUN: begin
                    if (r_counting) begin
                        n_underruns = sat_add32(r_underruns, 32'd1);
                    end
                end
                FN_FRAME: begin
                    if (r_counting) begin
                        if (r_last_frame != 48'd0) begin
                            n_frame_cnt = sat_add32(r_frame_cnt, 32'd1);
                            n_ft_sum    = sat_add48(r_ft_sum, elapsed);
                            if (elapsed > r_ft_max) begin
                                n_ft_max = elapsed;
                            end
                            if (r_ft_min == 48'd0 || elapsed < r_ft_min) begin
                                n_ft_min = elapsed;
                            end
                        end
                        n_last_frame = i_item.now_us;
                        n_draw_sum   = sat_add32(r_draw_sum, r_draws_if);
                        n_vert_sum   = sat_add48(r_vert_sum, {16'd0, r_verts_if});
                        if (r_draws_if > r_draw_pk) begin
                            n_draw_pk = r_draws_if;
                        end
                        if (r_verts_if > r_vert_pk) begin
                            n_vert_pk = r_verts_if;
                        end
                        if ($signed(r_bytes_if) > $signed(r_byte_pk)) begin
                            n_byte_pk = r_bytes_if;
                        end
                        n_draws_if = '0;
                        n_verts_if = '0;
                        n_bytes_if = '0;
                        if (period_end) begin
                            o_run.valid      = (n_frame_cnt != 32'd0);
                            o_run.has_sound  = (r_snd_blocks != 32'd0);
                            o_run.elapsed    = period_diff[47:0];
                            o_run.frames     = n_frame_cnt;
                            o_run.ft_sum     = n_ft_sum;
                            o_run.ft_min     = n_ft_min;
                            o_run.ft_max     = n_ft_max;
                            o_run.draws      = n_draw_sum;
                            o_run.draw_pk    = n_draw_pk;
                            o_run.verts      = n_vert_sum;
                            o_run.vert_pk    = n_vert_pk;
                            o_run.byte_pk    = n_byte_pk;
                            o_run.buf_b      = r_buf_b;
                            o_run.tex_b      = r_tex_b;
                            o_run.snd_blocks = r_snd_blocks;
                            o_run.snd_frames = r_snd_frames;
                            o_run.mix_sum    = r_mix_sum;
                            o_run.mix_pk     = r_mix_pk;
                            o_run.voice_pk   = r_voice_pk;
                            o_run.underruns  = r_underruns;

                            n_period_start = i_item.now_us;
                            n_frame_cnt    = '0;
                            n_ft_sum       = '0;
                            n_ft_max       = '0;
                            n_ft_min       = '0;
                            n_draw_sum     = '0;
                            n_vert_sum     = '0;
                            n_draw_pk      = '0;
                            n_vert_pk      = '0;
                            n_byte_pk      = '0;
                            n_snd_blocks   = '0;
                            n_snd_frames   = '0;
                            n_mix_sum      = '0;
                            n_mix_pk       = '0;
                            n_voice_pk     = '0;
                            n_underruns    = '0;
                        end
                    end
                end
                FN_BUFMEM: begin
                    n_buf_b = clamp_s48(r_buf_b, i_item.count_b);
                end
                FN_TEXMEM: begin
                    n_tex_b = clamp_s48(r_tex_b, i_item.count_b);
                end
                FN_RESTART: begin
                    n_period_start = i_item.now_us;
                    n_last_frame   = '0;
                    n_frame_cnt    = '0;
                    n_ft_sum       = '0;
                    n_ft_max       = '0;
                    n_ft_min       = '0;
                    n_draw_sum     = '0;
                    n_vert_sum     = '0;
                    n_draw_pk      = '0;
                    n_vert_pk      = '0;
                    n_byte_pk      = '0;
                    n_snd_blocks   = '0;
                    n_snd_frames   = '0;
                    n_mix_sum      = '0;
                    n_mix_pk       = '0;
                    n_voice_pk     = '0;
                    n_underruns    = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_counting   <= 1'b0;
            r_period_len <= PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_COUNTING: begin
                    r_counting <= i_cfg_data[0];
                end
                CFG_PERIOD: begin
                    r_period_len <= (i_cfg_data < PERIOD_MIN) ? PERIOD_MIN : i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period_start <= '0;
            r_last_frame   <= '0;
            r_frame_cnt    <= '0;
            r_ft_sum       <= '0;
            r_ft_max       <= '0;
            r_ft_min       <= '0;
            r_draw_sum     <= '0;
            r_vert_sum     <= '0;
            r_draw_pk      <= '0;
            r_vert_pk      <= '0;
            r_byte_pk      <= '0;
            r_draws_if     <= '0;
            r_verts_if     <= '0;
            r_bytes_if     <= '0;
            r_buf_b        <= '0;
            r_tex_b        <= '0;
            r_snd_blocks   <= '0;
            r_snd_frames   <= '0;
            r_mix_sum      <= '0;
            r_mix_pk       <= '0;
            r_voice_pk     <= '0;
            r_underruns    <= '0;
        end else begin
            r_period_start <= n_period_start;
            r_last_frame   <= n_last_frame;
            r_frame_cnt    <= n_frame_cnt;
            r_ft_sum       <= n_ft_sum;
            r_ft_max       <= n_ft_max;
            r_ft_min       <= n_ft_min;
            r_draw_sum     <= n_draw_sum;
            r_vert_sum     <= n_vert_sum;
            r_draw_pk      <= n_draw_pk;
            r_vert_pk      <= n_vert_pk;
            r_byte_pk      <= n_byte_pk;
            r_draws_if     <= n_draws_if;
            r_verts_if     <= n_verts_if;
            r_bytes_if     <= n_bytes_if;
            r_buf_b        <= n_buf_b;
            r_tex_b        <= n_tex_b;
            r_snd_blocks   <= n_snd_blocks;
            r_snd_frames   <= n_snd_frames;
            r_mix_sum      <= n_mix_sum;
            r_mix_pk       <= n_mix_pk;
            r_voice_pk     <= n_voice_pk;
            r_underruns    <= n_underruns;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/fstat_report.sv
// Summary snapshot register, statistic sequencer and output register.
// Depends on fstat_pkg and fstat_out_if.
`default_nettype none

module fstat_report (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire fstat_pkg::t_run i_run,
    output logic                 o_busy,
    fstat_out_if.source          o_stat
);
    import fstat_pkg::*;

    t_run        r_snap;
    logic        r_active;
    t_stat_id    r_idx;
    logic        r_out_valid;
    logic [4:0]  r_out_id;
    logic [63:0] r_out_val;
    logic        r_out_last;

    logic        slot_free;
    logic        load;
    logic        is_last;
    logic [63:0] sel_val;

    assign slot_free = !r_out_valid || o_stat.ready;
    assign load      = r_active && slot_free;
    assign is_last   = (r_idx == ST_TEXMEM && !r_snap.has_sound) || r_idx == ST_UNDERRUNS;
    assign o_busy    = r_active;

    always_comb begin
        case (r_idx)
            ST_PERIOD:     sel_val = {16'd0, r_snap.elapsed};
            ST_FRAMES:     sel_val = {32'd0, r_snap.frames};
            ST_FRAMETOTAL: sel_val = {16'd0, r_snap.ft_sum};
            ST_BEST:       sel_val = {16'd0, r_snap.ft_min};
            ST_WORST:      sel_val = {16'd0, r_snap.ft_max};
            ST_DRAWS:      sel_val = {32'd0, r_snap.draws};
            ST_DRAWWORST:  sel_val = {32'd0, r_snap.draw_pk};
            ST_VERTS:      sel_val = {16'd0, r_snap.verts};
            ST_VERTWORST:  sel_val = {32'd0, r_snap.vert_pk};
            ST_BYTEWORST:  sel_val = {{32{r_snap.byte_pk[31]}}, r_snap.byte_pk};
            ST_BUFMEM:     sel_val = {{16{r_snap.buf_b[47]}}, r_snap.buf_b};
            ST_TEXMEM:     sel_val = {{16{r_snap.tex_b[47]}}, r_snap.tex_b};
            ST_SNDBLOCKS:  sel_val = {32'd0, r_snap.snd_blocks};
            ST_SNDFRAMES:  sel_val = {16'd0, r_snap.snd_frames};
            ST_MIXSUM:     sel_val = {16'd0, r_snap.mix_sum};
            ST_MIXWORST:   sel_val = {32'd0, r_snap.mix_pk};
            ST_VOICEPEAK:  sel_val = {56'd0, r_snap.voice_pk};
            ST_UNDERRUNS:  sel_val = {32'd0, r_snap.underruns};
            default:       sel_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_idx       <= ST_PERIOD;
            r_out_valid <= 1'b0;
        end else begin
            if (i_run.valid) begin
                r_active <= 1'b1;
                r_idx    <= ST_PERIOD;
            end else if (load) begin
                if (is_last) begin
                    r_active <= 1'b0;
                end else begin
                    r_idx <= t_stat_id'(r_idx + 5'd1);
                end
            end
            if (slot_free) begin
                r_out_valid <= r_active;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_run.valid) begin
            r_snap <= i_run;
        end
        if (load) begin
            r_out_id   <= r_idx;
            r_out_val  <= sel_val;
            r_out_last <= is_last;
        end
    end

    assign o_stat.valid       = r_out_valid;
    assign o_stat.stat_id     = r_out_id;
    assign o_stat.stat_value  = r_out_val;
    assign o_stat.last_of_run = r_out_last;

endmodule

`default_nettype wire

// File: hw/rtl/frame_statistics_monitor.sv
// Frame statistics monitor top level: input register, accumulators, report sequencer.
// Depends on fstat_pkg, fstat_in_if, fstat_out_if, fstat_accum, fstat_report
// and frame_statistics_monitor_macros.svh.
//
//   port     direction  beat
//   i_evt    in         one event: func, now_us, count_a, count_b, mix_us, voices
//   o_stat   out        one statistic: stat_id, stat_value, last_of_run
//   i_cfg_*  in         register write, no handshake, no read-back
//
// One event per cycle unless a frame event is held; the accumulators register its update from the input register.
// A summary run (12 or 18 beats) drains from a snapshot register one beat per
// cycle; a frame event waits in the input register while a run is draining.
// Other events keep flowing during a run. Reset is synchronous and clears all
// counters; o_stat stalls hold the output register and then the sequencer.
`default_nettype none

`include "frame_statistics_monitor_macros.svh"

module frame_statistics_monitor (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    fstat_in_if.sink         i_evt,
    fstat_out_if.source      o_stat
);
    import fstat_pkg::*;

    logic  r_in_valid;
    t_item r_in;
    logic  take;
    logic  rpt_busy;
    t_run  run;

    assign i_evt.ready = !r_in_valid || take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.valid && i_evt.ready) begin
            r_in_valid <= 1'b1;
        end else if (take) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_in.func    <= t_func'(i_evt.func);
            r_in.now_us  <= i_evt.now_us;
            r_in.count_a <= i_evt.count_a;
            r_in.count_b <= i_evt.count_b;
            r_in.mix_us  <= i_evt.mix_us;
            r_in.voices  <= i_evt.voices;
        end
    end

    fstat_accum u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item       (r_in),
        .i_item_valid (r_in_valid),
        .i_rpt_busy   (rpt_busy),
        .o_take       (take),
        .o_run        (run)
    );

    fstat_report u_report (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (run),
        .o_busy  (rpt_busy),
        .o_stat  (o_stat)
    );

    `FSTAT_ASSERT_IMP(a_run_not_busy, i_clk, i_rst_n, run.valid, !rpt_busy, "run started while report busy")
    `FSTAT_ASSERT_IMP(a_last_id, i_clk, i_rst_n, o_stat.valid && o_stat.last_of_run, o_stat.stat_id == ST_TEXMEM || o_stat.stat_id == ST_UNDERRUNS, "last beat has wrong id")
    `FSTAT_ASSERT_NXT(a_run_gapless, i_clk, i_rst_n, o_stat.valid && o_stat.ready && !o_stat.last_of_run, o_stat.valid, "gap inside a summary run")
    `FSTAT_ASSERT_IMP(a_frame_held, i_clk, i_rst_n, r_in_valid && r_in.func == FN_FRAME && rpt_busy, !take, "frame taken during a run")

endmodule

`default_nettype wire
